// File: sv/cmts_pkg.sv
// Shared definitions for the multi-rate CAN transmit scheduler.
// Holds field widths, codes, the control word type and the sequencer program.
// No dependencies.
package cmts_pkg;

    // Field widths.
    localparam int ID_W     = 29;
    localparam int CLS_W    = 3;
    localparam int MODE_W   = 2;
    localparam int US_W     = 32;
    localparam int MS_W     = 11;
    localparam int PERIOD_W = 10;
    localparam int ENTRY_W  = ID_W + CLS_W;

    // Default table sizes.
    localparam int PERIODIC_ENTRIES_DEF = 16;
    localparam int QUERY_ENTRIES_DEF    = 16;

    // Reset value of the query period register.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

    // Timing constants.
    localparam logic [US_W-1:0] US_PER_MS  = US_W'(1000);
    localparam logic [MS_W-1:0] MS_WRAP    = MS_W'(1000);
    localparam logic [MS_W-1:0] MS_MAX     = MS_W'(1001);
    localparam logic [MS_W-1:0] MARK_10MS  = MS_W'(10);
    localparam logic [MS_W-1:0] MARK_100MS = MS_W'(100);
    localparam logic [MS_W-1:0] MARK_200MS = MS_W'(200);

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_POLL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIMER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

    // Rate class codes.
    localparam logic [CLS_W-1:0] CLS_QUERY = 3'd0;
    localparam logic [CLS_W-1:0] CLS_100HZ = 3'd1;
    localparam logic [CLS_W-1:0] CLS_10HZ  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_5HZ   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_1HZ   = 3'd4;

    // Tick increments.
    localparam logic [1:0] INC_POLL  = 2'd1;
    localparam logic [1:0] INC_TIMER = 2'd2;

    // Micro-operations of the sequencer.
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DIFF,
        OP_ACC,
        OP_TICK,
        OP_QUERY,
        OP_CHECK,
        OP_SCAN,
        OP_FLUSH
    } op_t;

    localparam int UPC_W = 4;

    // One control word: operation, class operand and branch target.
    typedef struct packed {
        op_t              op;
        logic [CLS_W-1:0] cls;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // Program addresses.
    localparam logic [UPC_W-1:0] A_WAIT  = 4'd0;
    localparam logic [UPC_W-1:0] A_DIFF  = 4'd1;
    localparam logic [UPC_W-1:0] A_ACC   = 4'd2;
    localparam logic [UPC_W-1:0] A_TICK  = 4'd3;
    localparam logic [UPC_W-1:0] A_QUERY = 4'd4;
    localparam logic [UPC_W-1:0] A_CHK1  = 4'd5;
    localparam logic [UPC_W-1:0] A_SCAN1 = 4'd6;
    localparam logic [UPC_W-1:0] A_CHK2  = 4'd7;
    localparam logic [UPC_W-1:0] A_SCAN2 = 4'd8;
    localparam logic [UPC_W-1:0] A_CHK3  = 4'd9;
    localparam logic [UPC_W-1:0] A_SCAN3 = 4'd10;
    localparam logic [UPC_W-1:0] A_CHK4  = 4'd11;
    localparam logic [UPC_W-1:0] A_SCAN4 = 4'd12;
    localparam logic [UPC_W-1:0] A_FLUSH = 4'd13;

    // Sequencer program. A check step jumps to its target when the class is
    // not due or the periodic table is empty; the wait step jumps to its target
    // on a timer tick; the accumulate step jumps to its target when no tick occurs.
    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        case (addr)
            A_WAIT:  w = '{op: OP_WAIT,  cls: CLS_QUERY, target: A_TICK};
            A_DIFF:  w = '{op: OP_DIFF,  cls: CLS_QUERY, target: A_ACC};
            A_ACC:   w = '{op: OP_ACC,   cls: CLS_QUERY, target: A_WAIT};
            A_TICK:  w = '{op: OP_TICK,  cls: CLS_QUERY, target: A_QUERY};
            A_QUERY: w = '{op: OP_QUERY, cls: CLS_QUERY, target: A_CHK1};
            A_CHK1:  w = '{op: OP_CHECK, cls: CLS_100HZ, target: A_CHK2};
            A_SCAN1: w = '{op: OP_SCAN,  cls: CLS_100HZ, target: A_CHK2};
            A_CHK2:  w = '{op: OP_CHECK, cls: CLS_10HZ,  target: A_CHK3};
            A_SCAN2: w = '{op: OP_SCAN,  cls: CLS_10HZ,  target: A_CHK3};
            A_CHK3:  w = '{op: OP_CHECK, cls: CLS_5HZ,   target: A_CHK4};
            A_SCAN3: w = '{op: OP_SCAN,  cls: CLS_5HZ,   target: A_CHK4};
            A_CHK4:  w = '{op: OP_CHECK, cls: CLS_1HZ,   target: A_FLUSH};
            A_SCAN4: w = '{op: OP_SCAN,  cls: CLS_1HZ,   target: A_FLUSH};
            A_FLUSH: w = '{op: OP_FLUSH, cls: CLS_QUERY, target: A_WAIT};
            default: w = '{op: OP_FLUSH, cls: CLS_QUERY, target: A_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: sv/can_multirate_tx_scheduler_top.sv
// Multi-rate periodic CAN transmit scheduler, microcoded sequencer and datapath.
// Depends on cmts_pkg for widths, codes and the sequencer program.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------------
//  command | cmd_valid / cmd_stall  | mode, now_us, entry_can_id, entry_rate
//  send    | send_valid / send_stall| send_id, send_class, last_of_tick
//  config  | cfg_valid / cfg_ready  | cfg_data (query period in ms)
//
// The sequencer freezes while a matching table read finds the pending result and a
// stalled output register both full; the final step also waits for the output register.
// Reset is asynchronous and clears all control state; the tables need no
// clearing since only entries below the fill counts are ever read.
module can_multirate_tx_scheduler_top
    import cmts_pkg::*;
#(
    parameter int PERIODIC_ENTRIES = PERIODIC_ENTRIES_DEF,
    parameter int QUERY_ENTRIES    = QUERY_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [US_W-1:0]     now_us,
    input  logic [ID_W-1:0]     entry_can_id,
    input  logic [CLS_W-1:0]    entry_rate,
    // Send channel
    output logic                send_valid,
    input  logic                send_stall,
    output logic [ID_W-1:0]     send_id,
    output logic [CLS_W-1:0]    send_class,
    output logic                last_of_tick,
    // Configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    // Table index and count widths.
    localparam int PA_W = (PERIODIC_ENTRIES > 1) ? $clog2(PERIODIC_ENTRIES) : 1;
    localparam int PC_W = $clog2(PERIODIC_ENTRIES + 1);
    localparam int QA_W = (QUERY_ENTRIES > 1) ? $clog2(QUERY_ENTRIES) : 1;
    localparam int QC_W = $clog2(QUERY_ENTRIES + 1);
    localparam logic [PC_W-1:0] P_FULL = PC_W'(PERIODIC_ENTRIES);
    localparam logic [QC_W-1:0] Q_FULL = QC_W'(QUERY_ENTRIES);

    // Sequencer and timing state.
    logic [UPC_W-1:0]    upc_reg, upc_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [MS_W-1:0]     ms_reg, ms_next;
    logic [MS_W-1:0]     lq_reg, lq_next;
    logic [MS_W-1:0]     m10_reg, m10_next;
    logic [MS_W-1:0]     m100_reg, m100_next;
    logic [MS_W-1:0]     m200_reg, m200_next;
    logic [US_W-1:0]     prev_reg, prev_next;
    logic [US_W-1:0]     acc_reg, acc_next;
    logic [US_W-1:0]     now_reg, now_next;
    logic [US_W-1:0]     diff_reg, diff_next;
    logic [1:0]          inc_reg, inc_next;

    // Table bookkeeping.
    logic [PC_W-1:0]     pcount_reg, pcount_next;
    logic [QC_W-1:0]     qcount_reg, qcount_next;
    logic [QA_W-1:0]     qptr_reg, qptr_next;
    logic [PA_W-1:0]     idx_reg, idx_next;

    // Table read stage.
    logic                rdv_reg, rdv_next;
    logic                rdq_reg, rdq_next;
    logic [CLS_W-1:0]    rdcls_reg, rdcls_next;
    logic [ENTRY_W-1:0]  pt_rd_reg;
    logic [ID_W-1:0]     qt_rd_reg;

    // Pending result, held until it is known whether another result follows.
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [CLS_W-1:0]    pend_cls_reg, pend_cls_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [CLS_W-1:0]    out_cls_reg, out_cls_next;
    logic                out_last_reg, out_last_next;

    // Tables.
    logic [ENTRY_W-1:0]  ptab [PERIODIC_ENTRIES];
    logic [ID_W-1:0]     qtab [QUERY_ENTRIES];

    ctrl_t               ctrl;
    logic                cmd_take;
    logic                b_match;
    logic                out_free;
    logic                hold;
    logic                pt_we;
    logic                qt_we;
    logic                pt_re;
    logic                qt_re;
    logic [US_W-1:0]     acc_sum;
    logic [MS_W-1:0]     el_q;
    logic [MS_W-1:0]     el_10;
    logic [MS_W-1:0]     el_100;
    logic [MS_W-1:0]     el_200;
    logic                due;
    logic [QC_W-1:0]     qptr_inc;
    logic                idx_last;

    assign ctrl      = ucode_rom(upc_reg);
    assign cmd_stall = (upc_reg != A_WAIT);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;

    assign send_valid   = out_valid_reg;
    assign send_id      = out_id_reg;
    assign send_class   = out_cls_reg;
    assign last_of_tick = out_last_reg;

    // Elapsed times and derived compares.
    assign el_q     = ms_reg - lq_reg;
    assign el_10    = ms_reg - m10_reg;
    assign el_100   = ms_reg - m100_reg;
    assign el_200   = ms_reg - m200_reg;
    assign acc_sum  = acc_reg + diff_reg;
    assign qptr_inc = QC_W'(qptr_reg) + QC_W'(1);
    assign idx_last = ((PC_W'(idx_reg) + PC_W'(1)) == pcount_reg);

    // Read stage match and back-pressure.
    assign b_match  = rdv_reg && (rdq_reg || (pt_rd_reg[ID_W +: CLS_W] == rdcls_reg));
    assign out_free = !out_valid_reg || !send_stall;
    assign hold     = b_match && pend_valid_reg && !out_free;

    // Class due test for the current check step.
    always_comb
    begin
        case (ctrl.cls)
            CLS_100HZ: due = (el_10 >= MARK_10MS);
            CLS_10HZ:  due = (el_100 >= MARK_100MS);
            CLS_5HZ:   due = (el_200 >= MARK_200MS);
            CLS_1HZ:   due = (ms_reg >= MS_WRAP);
            default:   due = 1'b0;
        endcase
    end

    // Next-state logic for the sequencer and datapath.
    always_comb
    begin
        upc_next        = upc_reg;
        period_next     = period_reg;
        ms_next         = ms_reg;
        lq_next         = lq_reg;
        m10_next        = m10_reg;
        m100_next       = m100_reg;
        m200_next       = m200_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        now_next        = now_reg;
        diff_next       = diff_reg;
        inc_next        = inc_reg;
        pcount_next     = pcount_reg;
        qcount_next     = qcount_reg;
        qptr_next       = qptr_reg;
        idx_next        = idx_reg;
        rdv_next        = rdv_reg;
        rdq_next        = rdq_reg;
        rdcls_next      = rdcls_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_cls_next   = pend_cls_reg;
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_cls_next    = out_cls_reg;
        out_last_next   = out_last_reg;
        pt_we           = 1'b0;
        qt_we           = 1'b0;
        pt_re           = 1'b0;
        qt_re           = 1'b0;

        // Configuration write.
        if (cfg_valid && cfg_ready)
        begin
            period_next = cfg_data;
        end

        // Output register drains when the sink takes it.
        if (out_valid_reg && !send_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Matching read becomes the pending result; the old one moves out.
        if (b_match && !hold)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_id_next    = pend_id_reg;
                out_cls_next   = pend_cls_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = rdq_reg ? qt_rd_reg : pt_rd_reg[ID_W-1:0];
            pend_cls_next   = rdq_reg ? CLS_QUERY : rdcls_reg;
        end

        if (!hold)
        begin
            rdv_next = 1'b0;

            // Sequencer step.
            case (ctrl.op)
                OP_WAIT:
                begin
                    if (cmd_take)
                    begin
                        case (mode)
                            MODE_POLL:
                            begin
                                now_next = now_us;
                                inc_next = INC_POLL;
                                upc_next = A_DIFF;
                            end
                            MODE_TIMER:
                            begin
                                inc_next = INC_TIMER;
                                upc_next = ctrl.target;
                            end
                            MODE_ADD:
                            begin
                                if (entry_rate == CLS_QUERY)
                                begin
                                    if (qcount_reg < Q_FULL)
                                    begin
                                        qt_we       = 1'b1;
                                        qcount_next = qcount_reg + QC_W'(1);
                                    end
                                end
                                else if (pcount_reg < P_FULL)
                                begin
                                    pt_we       = 1'b1;
                                    pcount_next = pcount_reg + PC_W'(1);
                                end
                            end
                            default:
                            begin
                                upc_next = A_WAIT;
                            end
                        endcase
                    end
                end

                OP_DIFF:
                begin
                    // Wrapping difference, one short when now is below prev; equal samples give all ones.
                    if (prev_reg < now_reg)
                    begin
                        diff_next = now_reg - prev_reg;
                    end
                    else
                    begin
                        diff_next = now_reg + ~prev_reg;
                    end
                    prev_next = now_reg;
                    upc_next  = ctrl.target;
                end

                OP_ACC:
                begin
                    if (acc_sum >= US_PER_MS)
                    begin
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                    if ((acc_sum >= US_PER_MS) || (acc_sum == '0))
                    begin
                        upc_next = upc_reg + UPC_W'(1);
                    end
                    else
                    begin
                        upc_next = ctrl.target;
                    end
                end

                OP_TICK:
                begin
                    ms_next  = ms_reg + MS_W'(inc_reg);
                    upc_next = ctrl.target;
                end

                OP_QUERY:
                begin
                    if (el_q >= MS_W'(period_reg))
                    begin
                        lq_next = ms_reg;
                        if (qcount_reg != '0)
                        begin
                            qt_re    = 1'b1;
                            rdv_next = 1'b1;
                            rdq_next = 1'b1;
                            if (qptr_inc == qcount_reg)
                            begin
                                qptr_next = '0;
                            end
                            else
                            begin
                                qptr_next = qptr_inc[QA_W-1:0];
                            end
                        end
                    end
                    upc_next = ctrl.target;
                end

                OP_CHECK:
                begin
                    if (due)
                    begin
                        case (ctrl.cls)
                            CLS_100HZ: m10_next  = ms_reg;
                            CLS_10HZ:  m100_next = ms_reg;
                            CLS_5HZ:   m200_next = ms_reg;
                            CLS_1HZ:
                            begin
                                ms_next   = '0;
                                lq_next   = '0;
                                m10_next  = '0;
                                m100_next = '0;
                                m200_next = '0;
                            end
                            default:
                            begin
                                ms_next = ms_reg;
                            end
                        endcase
                    end
                    if (due && (pcount_reg != '0))
                    begin
                        idx_next = '0;
                        upc_next = upc_reg + UPC_W'(1);
                    end
                    else
                    begin
                        upc_next = ctrl.target;
                    end
                end

                OP_SCAN:
                begin
                    pt_re      = 1'b1;
                    rdv_next   = 1'b1;
                    rdq_next   = 1'b0;
                    rdcls_next = ctrl.cls;
                    idx_next   = idx_reg + PA_W'(1);
                    if (idx_last)
                    begin
                        upc_next = ctrl.target;
                    end
                end

                OP_FLUSH:
                begin
                    // Last result of the tick leaves once the read stage is empty and the output register is free.
                    if (!rdv_reg && (!pend_valid_reg || out_free))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_cls_next   = pend_cls_reg;
                            out_last_next  = 1'b1;
                        end
                        pend_valid_next = 1'b0;
                        upc_next        = ctrl.target;
                    end
                end

                default:
                begin
                    upc_next = A_WAIT;
                end
            endcase
        end
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= A_WAIT;
            period_reg     <= PERIOD_RESET;
            ms_reg         <= '0;
            lq_reg         <= '0;
            m10_reg        <= '0;
            m100_reg       <= '0;
            m200_reg       <= '0;
            prev_reg       <= '0;
            acc_reg        <= '0;
            now_reg        <= '0;
            diff_reg       <= '0;
            inc_reg        <= INC_POLL;
            pcount_reg     <= '0;
            qcount_reg     <= '0;
            qptr_reg       <= '0;
            idx_reg        <= '0;
            rdv_reg        <= 1'b0;
            rdq_reg        <= 1'b0;
            rdcls_reg      <= CLS_QUERY;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            pend_cls_reg   <= CLS_QUERY;
            out_valid_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_cls_reg    <= CLS_QUERY;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            period_reg     <= period_next;
            ms_reg         <= ms_next;
            lq_reg         <= lq_next;
            m10_reg        <= m10_next;
            m100_reg       <= m100_next;
            m200_reg       <= m200_next;
            prev_reg       <= prev_next;
            acc_reg        <= acc_next;
            now_reg        <= now_next;
            diff_reg       <= diff_next;
            inc_reg        <= inc_next;
            pcount_reg     <= pcount_next;
            qcount_reg     <= qcount_next;
            qptr_reg       <= qptr_next;
            idx_reg        <= idx_next;
            rdv_reg        <= rdv_next;
            rdq_reg        <= rdq_next;
            rdcls_reg      <= rdcls_next;
            pend_valid_reg <= pend_valid_next;
            pend_id_reg    <= pend_id_next;
            pend_cls_reg   <= pend_cls_next;
            out_valid_reg  <= out_valid_next;
            out_id_reg     <= out_id_next;
            out_cls_reg    <= out_cls_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Periodic table: written at the fill count, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            ptab[pcount_reg[PA_W-1:0]] <= {entry_rate, entry_can_id};
        end
        if (pt_re)
        begin
            pt_rd_reg <= ptab[idx_reg];
        end
    end

    // Query table: written at the fill count, read at the round-robin pointer.
    always_ff @(posedge clk)
    begin
        if (qt_we)
        begin
            qtab[qcount_reg[QA_W-1:0]] <= entry_can_id;
        end
        if (qt_re)
        begin
            qt_rd_reg <= qtab[qptr_reg];
        end
    end

    // The read stage and pending result are empty whenever a command can enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == A_WAIT) |-> (!pend_valid_reg && !rdv_reg))
        else $error("read stage or pending result busy while idle");

    // A frozen sequencer keeps its step.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(upc_reg))
        else $error("sequencer advanced during back-pressure");

    // The round-robin pointer stays inside the filled part of the query table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (qcount_reg != '0) |-> (QC_W'(qptr_reg) < qcount_reg))
        else $error("query pointer beyond fill count");

    // Scans only read written entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_SCAN) |-> (PC_W'(idx_reg) < pcount_reg))
        else $error("scan index beyond fill count");

    // The millisecond counter clears at the wrap point.
    assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg <= MS_MAX)
        else $error("millisecond counter past wrap");

endmodule

// File: test/tb_can_multirate_tx_scheduler_top.sv
// Self-checking testbench for the multi-rate CAN transmit scheduler.
// It runs a directed table of requests and then random phases under several query periods.
// Results are checked against a scheduler model kept here. Depends on cmts_pkg and the top.
module tb_can_multirate_tx_scheduler_top;
    import cmts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;
    localparam logic [CLS_W-1:0]  CLS_SPARE5 = 3'd5;
    localparam logic [CLS_W-1:0]  CLS_SPARE6 = 3'd6;
    localparam logic [CLS_W-1:0]  CLS_SPARE7 = 3'd7;
    localparam logic [ID_W-1:0]   ID_MAX     = {ID_W{1'b1}};
    localparam logic [US_W-1:0]   US_MAX     = {US_W{1'b1}};

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 72;
    localparam int SETTLE       = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_WAIT     = 200000;
    localparam int CYCLE_LIMIT  = 6000000;

    // One transmit request as it leaves the block.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
        logic             last;
    } tx_request_t;

    // One command; fixed rows carry their expected outcome when it is obvious.
    typedef struct packed {
        logic [MODE_W-1:0] md;
        logic [US_W-1:0]   now;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  rate;
        logic              fixed;
        logic [1:0]        n_fixed;
        logic [ID_W-1:0]   fixed_id;
        logic [CLS_W-1:0]  fixed_cls;
    } sched_cmd_t;

    localparam sched_cmd_t DIRECTED [25] = '{
        '{MODE_TIMER, 32'd0,        29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_NONE,  US_MAX,       ID_MAX,       CLS_SPARE7, 1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        ID_MAX,       CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   US_MAX,       29'd0,        CLS_100HZ,  1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        ID_MAX,       CLS_1HZ,    1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'h0AAAAAAA, CLS_10HZ,   1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'h15555555, CLS_5HZ,    1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'h01234567, CLS_SPARE5, 1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'h10FEDCBA, CLS_SPARE6, 1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'h00C0FFEE, CLS_SPARE7, 1'b1, 2'd0, '0, '0},
        '{MODE_ADD,   32'd0,        29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd0,        ID_MAX,       CLS_SPARE7, 1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd500,      29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd1500,     29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  US_MAX,       29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd0,        29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd0,        29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd999,      29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_POLL,  32'd1000,     29'd0,        CLS_QUERY,  1'b1, 2'd0, '0, '0},
        '{MODE_TIMER, 32'd0,        29'd0,        CLS_QUERY,  1'b1, 2'd1, 29'd0, CLS_100HZ},
        '{MODE_TIMER, US_MAX,       ID_MAX,       CLS_SPARE7, 1'b0, 2'd0, '0, '0},
        '{MODE_TIMER, 32'd0,        29'd0,        CLS_QUERY,  1'b0, 2'd0, '0, '0},
        '{MODE_TIMER, 32'd0,        29'd0,        CLS_QUERY,  1'b0, 2'd0, '0, '0},
        '{MODE_TIMER, 32'd0,        29'd0,        CLS_QUERY,  1'b0, 2'd0, '0, '0},
        '{MODE_POLL,  32'd2000,     29'd0,        CLS_QUERY,  1'b0, 2'd0, '0, '0}
    };

    // Per phase: query period, sender gap and receiver stall percentages.
    localparam int PERIODS   [PHASES] = '{0, 1, 1000, 1023, 7, -1};
    localparam int GAP_PCT   [PHASES] = '{30, 0, 30, 25, 40, 20};
    localparam int STALL_PCT [PHASES] = '{30, 35, 0, 25, 40, 20};

    logic clk = 1'b0;
    logic rst_n;

    logic                cmd_valid;
    logic                cmd_stall;
    logic [MODE_W-1:0]   mode;
    logic [US_W-1:0]     now_us;
    logic [ID_W-1:0]     entry_can_id;
    logic [CLS_W-1:0]    entry_rate;
    logic                send_valid;
    logic                send_stall;
    logic [ID_W-1:0]     send_id;
    logic [CLS_W-1:0]    send_class;
    logic                last_of_tick;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data;

    can_multirate_tx_scheduler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .mode         (mode),
        .now_us       (now_us),
        .entry_can_id (entry_can_id),
        .entry_rate   (entry_rate),
        .send_valid   (send_valid),
        .send_stall   (send_stall),
        .send_id      (send_id),
        .send_class   (send_class),
        .last_of_tick (last_of_tick),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scheduler model state.
    logic [PERIOD_W-1:0] query_period;
    logic [MS_W-1:0]     ms_count;
    logic [MS_W-1:0]     query_mark;
    logic [MS_W-1:0]     mark_10ms;
    logic [MS_W-1:0]     mark_100ms;
    logic [MS_W-1:0]     mark_200ms;
    logic [US_W-1:0]     prev_us;
    logic [US_W-1:0]     us_acc;
    logic [ID_W-1:0]     periodic_ids [PERIODIC_ENTRIES_DEF];
    logic [CLS_W-1:0]    periodic_cls [PERIODIC_ENTRIES_DEF];
    int                  periodic_fill;
    logic [ID_W-1:0]     query_ids [QUERY_ENTRIES_DEF];
    int                  query_fill;
    int                  query_next;

    tx_request_t tick_requests [$];
    tx_request_t pending_tx [$];

    int  errors;
    int  cycles;
    int  gap_pct;
    int  stall_pct;
    int  stall_left;
    int  hold_left;
    bit  hold_req;

    function automatic logic [MS_W-1:0] ms_since(input logic [MS_W-1:0] mark);
        return ms_count - mark;
    endfunction

    // Emit every periodic entry of one class, in table order.
    task automatic scan_class(input logic [CLS_W-1:0] cls);
        for (int i = 0; i < periodic_fill; i++)
        begin
            if (periodic_cls[i] == cls)
                tick_requests.push_back('{id: periodic_ids[i], cls: cls, last: 1'b0});
        end
    endtask

    // Advance the model by one command and collect the transmit requests it causes.
    task automatic schedule_step(input sched_cmd_t c);
        logic [US_W-1:0] diff;
        logic [MS_W-1:0] inc;
        tx_request_t     r;
        tick_requests.delete();
        if (c.md == MODE_ADD)
        begin
            if (c.rate == CLS_QUERY)
            begin
                if (query_fill < QUERY_ENTRIES_DEF)
                begin
                    query_ids[query_fill] = c.id;
                    query_fill++;
                end
            end
            else if (periodic_fill < PERIODIC_ENTRIES_DEF)
            begin
                periodic_ids[periodic_fill] = c.id;
                periodic_cls[periodic_fill] = c.rate;
                periodic_fill++;
            end
            return;
        end
        if (c.md == MODE_NONE)
            return;
        if (c.md == MODE_POLL)
        begin
            // Equal samples count as all ones, one short of a full wrap of the microsecond clock.
            diff = (prev_us < c.now) ? c.now - prev_us : (US_MAX - prev_us) + c.now;
            prev_us = c.now;
            us_acc = us_acc + diff;
            if (us_acc >= US_PER_MS)
                us_acc = '0;
            if (us_acc != '0)
                return;
            inc = MS_W'(INC_POLL);
        end
        else
        begin
            inc = MS_W'(INC_TIMER);
        end
        ms_count = ms_count + inc;

        // Round-robin query entry, then the periodic classes in rate order.
        if (ms_since(query_mark) >= MS_W'(query_period))
        begin
            if (query_fill != 0)
            begin
                tick_requests.push_back('{id: query_ids[query_next], cls: CLS_QUERY,
                                          last: 1'b0});
                query_next = (query_next == query_fill - 1) ? 0 : (query_next + 1) & 15;
            end
            query_mark = ms_count;
        end
        if (ms_since(mark_10ms) >= MARK_10MS)
        begin
            scan_class(CLS_100HZ);
            mark_10ms = ms_count;
        end
        if (ms_since(mark_100ms) >= MARK_100MS)
        begin
            scan_class(CLS_10HZ);
            mark_100ms = ms_count;
        end
        if (ms_since(mark_200ms) >= MARK_200MS)
        begin
            scan_class(CLS_5HZ);
            mark_200ms = ms_count;
        end
        if (ms_count >= MS_WRAP)
        begin
            scan_class(CLS_1HZ);
            ms_count   = '0;
            query_mark = '0;
            mark_10ms  = '0;
            mark_100ms = '0;
            mark_200ms = '0;
        end
        if (tick_requests.size() > 0)
        begin
            r = tick_requests[tick_requests.size() - 1];
            r.last = 1'b1;
            tick_requests[tick_requests.size() - 1] = r;
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command and wait for the block to take it.
    task automatic issue(input sched_cmd_t c);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        mode         <= c.md;
        now_us       <= c.now;
        entry_can_id <= c.id;
        entry_rate   <= c.rate;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        schedule_step(c);
        if (c.fixed)
        begin
            if (c.n_fixed != 0)
                pending_tx.push_back('{id: c.fixed_id, cls: c.fixed_cls, last: 1'b1});
        end
        else
        begin
            foreach (tick_requests[i])
                pending_tx.push_back(tick_requests[i]);
        end
    endtask

    // Next microsecond sample: mostly about one millisecond on, sometimes odd.
    function automatic logic [US_W-1:0] next_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return prev_us + US_W'($urandom_range(950, 1050));
        if (r < 85)
            return prev_us + US_W'($urandom_range(1, 500));
        if (r < 92)
            return prev_us;
        if (r < 96)
            return $urandom;
        return US_MAX - US_W'($urandom_range(0, 600));
    endfunction

    function automatic sched_cmd_t random_cmd();
        sched_cmd_t c;
        int         r;
        int         k;
        c = '0;
        c.now  = $urandom;
        c.id   = ID_W'($urandom);
        c.rate = CLS_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            c.md = MODE_TIMER;
        end
        else if (r < 72)
        begin
            c.md  = MODE_POLL;
            c.now = next_sample();
        end
        else if (r < 90)
        begin
            c.md = MODE_ADD;
            k = $urandom_range(0, 99);
            if (k < 25)
                c.rate = CLS_QUERY;
            else if (k < 85)
                c.rate = CLS_W'($urandom_range(1, 4));
            else
                c.rate = CLS_W'($urandom_range(5, 7));
            k = $urandom_range(0, 19);
            if (k == 0)
                c.id = '0;
            else if (k == 1)
                c.id = ID_MAX;
        end
        else
        begin
            c.md = MODE_NONE;
        end
        return c;
    endfunction

    // Stop offering and wait for every expected request, then let the block settle.
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_tx.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        query_period = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold when requested.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            send_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            send_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            if ($urandom_range(0, 99) < 85)
                stall_left = $urandom_range(0, 2);
            else
                stall_left = $urandom_range(9, 39);
            send_stall <= 1'b1;
        end
        else
        begin
            send_stall <= 1'b0;
        end
    end

    // Compare each accepted transmit request with the oldest expectation.
    always @(posedge clk)
    begin
        tx_request_t exp_req;
        if (rst_n && send_valid && !send_stall)
        begin
            if (pending_tx.size() == 0)
            begin
                $error("unexpected transmit request: id %h class %0d last %0b",
                       send_id, send_class, last_of_tick);
                errors++;
            end
            else
            begin
                exp_req = pending_tx.pop_front();
                if (send_id !== exp_req.id)
                begin
                    $error("send_id mismatch: expected %h, got %h", exp_req.id, send_id);
                    errors++;
                end
                if (send_class !== exp_req.cls)
                begin
                    $error("send_class mismatch: expected %0d, got %0d",
                           exp_req.cls, send_class);
                    errors++;
                end
                if (last_of_tick !== exp_req.last)
                begin
                    $error("last_of_tick mismatch: expected %0b, got %0b",
                           exp_req.last, last_of_tick);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        int         count;
        int         waited;
        sched_cmd_t c;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        mode         = MODE_NONE;
        now_us       = '0;
        entry_can_id = '0;
        entry_rate   = CLS_QUERY;
        send_stall   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        errors       = 0;
        cycles       = 0;
        gap_pct      = 25;
        stall_pct    = 25;
        stall_left   = 0;
        hold_left    = 0;
        hold_req     = 1'b0;

        // Model state after reset.
        query_period  = PERIOD_RESET;
        ms_count      = '0;
        query_mark    = '0;
        mark_10ms     = '0;
        mark_100ms    = '0;
        mark_200ms    = '0;
        prev_us       = '0;
        us_acc        = '0;
        periodic_fill = 0;
        query_fill    = 0;
        query_next    = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset query period.
        for (int i = 0; i < 25; i++)
            issue(DIRECTED[i]);

        // Random phases, each under its own query period.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (PERIODS[p] < 0)
                write_period(PERIOD_W'($urandom_range(2, 999)));
            else
                write_period(PERIOD_W'(PERIODS[p]));
            gap_pct   = GAP_PCT[p];
            stall_pct = STALL_PCT[p];
            // Hold the receiver off while commands keep coming.
            if (p == 0)
                hold_req = 1'b1;
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                c = random_cmd();
                issue(c);
                count++;
            end
        end

        // Wait for the last requests, then check that nothing is left over.
        @(negedge clk);
        cmd_valid <= 1'b0;
        waited = 0;
        while (pending_tx.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_tx.size() != 0)
        begin
            $error("%0d expected transmit requests never arrived", pending_tx.size());
            errors++;
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/cmts_pkg.sv
sv/can_multirate_tx_scheduler_top.sv
test/tb_can_multirate_tx_scheduler_top.sv
